FILE: hdl/pps_pkg.sv
package pps_pkg;

	// Power tables
	localparam int POW_TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(POW_TABLE_DEPTH);

	// Register indexes
	localparam logic [2:0] REG_LIGHT_X   = 3'd0;
	localparam logic [2:0] REG_LIGHT_Y   = 3'd1;
	localparam logic [2:0] REG_LIGHT_Z   = 3'd2;
	localparam logic [2:0] REG_LIGHT_RGB = 3'd3;
	localparam logic [2:0] REG_MATERIAL  = 3'd4;
	localparam logic [2:0] REG_SHININESS = 3'd5;

	// Register reset values
	localparam logic [47:0] LIGHT_RGB_RST = 48'd70369817935872;
	localparam logic [47:0] MATERIAL_RST  = 48'd15472369766;
	localparam logic [15:0] SHININESS_RST = 16'd12800;

	// Pipeline stage map
	localparam int ST_DIFF   = 1;
	localparam int ST_MAX    = 2;
	localparam int ST_NORM   = 3;
	localparam int ST_SQR    = 4;
	localparam int ST_SUM    = 5;
	localparam int ST_SQ0    = 6;
	localparam int SQ_STAGES = 7;
	localparam int SQ_ITERS  = 3;
	localparam int ST_DV0    = ST_SQ0 + SQ_STAGES;
	localparam int DV_STAGES = 5;
	localparam int DV_ITERS  = 3;
	localparam int ST_LV     = ST_DV0 + DV_STAGES;
	localparam int ST_NDL    = ST_LV + 1;
	localparam int ST_RN     = ST_LV + 2;
	localparam int ST_RV     = ST_LV + 3;
	localparam int ST_RE     = ST_LV + 4;
	localparam int ST_RDE    = ST_LV + 5;
	localparam int ST_LZ     = ST_LV + 6;
	localparam int ST_IDX    = ST_LV + 7;
	localparam int ST_LOG    = ST_LV + 8;
	localparam int ST_POW    = ST_LV + 9;
	localparam int ST_EIDX   = ST_LV + 10;
	localparam int ST_EXP    = ST_LV + 11;
	localparam int ST_EFF    = ST_LV + 12;
	localparam int ST_MUL    = ST_LV + 13;
	localparam int ST_DIF    = ST_LV + 14;
	localparam int ST_OUT    = ST_LV + 15;
	localparam int NS        = ST_OUT;

	typedef logic [15:0] log_tab_t [POW_TABLE_DEPTH];
	typedef logic [30:0] exp_tab_t [POW_TABLE_DEPTH];

	// Floor square root, two bits per step
	function automatic logic [63:0] isqrt64(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = val;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// log2(1 + i/D), 16 fraction bits, by repeated squaring
	function automatic log_tab_t build_log_tab();
		log_tab_t t;
		logic [63:0] x;
		logic [15:0] r;
		for (int i = 0; i < POW_TABLE_DEPTH; i++) begin
			x = ((64'(POW_TABLE_DEPTH) + 64'(i)) << 30) / 64'(POW_TABLE_DEPTH);
			r = '0;
			for (int k = 0; k < 16; k++) begin
				x = (x * x) >> 30;
				r = {r[14:0], 1'b0};
				if (x >= (64'd1 << 31)) begin
					r[0] = 1'b1;
					x = x >> 1;
				end
			end
			t[i] = r;
		end
		return t;
	endfunction

	// 2^(i/D) at Q1.30 from chained square roots of two
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t t;
		logic [63:0] roots [16];
		logic [63:0] f;
		logic [63:0] v;
		roots[0] = isqrt64(64'd1 << 61);
		for (int k = 1; k < 16; k++)
			roots[k] = isqrt64(roots[k-1] << 30);
		for (int i = 0; i < POW_TABLE_DEPTH; i++) begin
			f = (64'(i) << 16) / 64'(POW_TABLE_DEPTH);
			v = 64'd1 << 30;
			for (int k = 0; k < 16; k++)
				if (f[15-k])
					v = (v * roots[k]) >> 30;
			t[i] = v[30:0];
		end
		return t;
	endfunction

	localparam log_tab_t LOG_TAB = build_log_tab();
	localparam exp_tab_t EXP_TAB = build_exp_tab();

	// Everything one item carries down the pipeline
	typedef struct packed {
		logic              shadow;
		logic [47:0]       colour;
		logic [2:0][15:0]  nv;
		logic [2:0][15:0]  ev;
		logic [2:0]        neg;
		logic [2:0][32:0]  mag;
		logic              skip;
		logic [5:0]        pos;
		logic [2:0][19:0]  nmag;
		logic [2:0][39:0]  sq;
		logic [41:0]       rad;
		logic [21:0]       srem;
		logic [20:0]       root;
		logic [2:0][21:0]  drem;
		logic [2:0][14:0]  quo;
		logic [2:0][15:0]  lv;
		logic [2:0][31:0]  lnp;
		logic [32:0]       ndl;
		logic              lit;
		logic [2:0][47:0]  rnp;
		logic [2:0][20:0]  rv;
		logic [2:0][36:0]  rep;
		logic              spec;
		logic [14:0]       xq;
		logic              xzero;
		logic [3:0]        lead;
		logic [14:0]       mant;
		logic [IDX_W-1:0]  lidx;
		logic [19:0]       nlog;
		logic [29:0]       pw;
		logic              fzero;
		logic [13:0]       pint;
		logic [IDX_W-1:0]  eidx;
		logic [14:0]       factor;
		logic [2:0][17:0]  eff;
		logic [2:0][27:0]  cke;
		logic [2:0][27:0]  liks;
		logic [2:0][29:0]  amb;
		logic [2:0][29:0]  effkd;
		logic [2:0][42:0]  specp;
		logic [2:0][32:0]  dif;
		logic [2:0][28:0]  spc;
		logic [2:0][15:0]  chan;
		logic              sat;
	} pipe_t;

endpackage

FILE: hdl/pps_if.sv
// Hit point channel
interface pps_hit_if;
	logic        valid;
	logic        ready;
	logic [31:0] point_x;
	logic [31:0] point_y;
	logic [31:0] point_z;
	logic [15:0] eye_x;
	logic [15:0] eye_y;
	logic [15:0] eye_z;
	logic [15:0] normal_x;
	logic [15:0] normal_y;
	logic [15:0] normal_z;
	logic        in_shadow;
	logic [47:0] surface_colour;

	modport source (
		output valid, point_x, point_y, point_z, eye_x, eye_y, eye_z,
		       normal_x, normal_y, normal_z, in_shadow, surface_colour,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, point_z, eye_x, eye_y, eye_z,
		       normal_x, normal_y, normal_z, in_shadow, surface_colour,
		output ready
	);
endinterface

// Shaded colour channel
interface pps_pix_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_red;
	logic [15:0] out_green;
	logic [15:0] out_blue;
	logic        saturated;

	modport source (
		output valid, out_red, out_green, out_blue, saturated,
		input  ready
	);
	modport sink (
		input  valid, out_red, out_green, out_blue, saturated,
		output ready
	);
endinterface

FILE: hdl/phong_point_light_shading.sv
// Phong point-light shader, fully pipelined.
// 33 stages; the result is driven from the last stage's registers.
// One hit per cycle unless stalled; square root and divide unrolled over stages.
// Each stage holds its item under backpressure and bubbles close up behind a stall.
// Reset (arst_n low): pipeline emptied, light and material registers to defaults.
module phong_point_light_shading
	import pps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [47:0] wr_data,
	pps_hit_if.sink     hit,
	pps_pix_if.source   pixel
);

	logic [2:0][31:0] light_q;
	logic [47:0]      light_rgb_q;
	logic [47:0]      material_q;
	logic [15:0]      shin_q;

	logic [2:0][31:0] pt;
	logic [2:0][15:0] in_nv;
	logic [2:0][15:0] in_ev;

	logic [11:0] ka, kd, ks, ke;

	logic  [1:NS] vld_s;
	logic  [1:NS] en;
	pipe_t        pipe_s [1:NS];
	pipe_t        nxt    [1:NS];

	assign pt    = {hit.point_z, hit.point_y, hit.point_x};
	assign in_nv = {hit.normal_z, hit.normal_y, hit.normal_x};
	assign in_ev = {hit.eye_z, hit.eye_y, hit.eye_x};

	assign ka = material_q[11:0];
	assign kd = material_q[23:12];
	assign ks = material_q[35:24];
	assign ke = material_q[47:36];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q     <= '0;
			light_rgb_q <= LIGHT_RGB_RST;
			material_q  <= MATERIAL_RST;
			shin_q      <= SHININESS_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_LIGHT_X:   light_q[0]  <= wr_data[31:0];
				REG_LIGHT_Y:   light_q[1]  <= wr_data[31:0];
				REG_LIGHT_Z:   light_q[2]  <= wr_data[31:0];
				REG_LIGHT_RGB: light_rgb_q <= wr_data;
				REG_MATERIAL:  material_q  <= wr_data;
				REG_SHININESS: shin_q      <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	// Stage enables: a stage moves when empty or when the one after it moves
	always_comb begin
		en[NS] = !vld_s[NS] || pixel.ready;
		for (int k = NS - 1; k >= 1; k--)
			en[k] = !vld_s[k] || en[k+1];
	end

	assign hit.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1])
				vld_s[1] <= hit.valid;
			for (int k = 2; k <= NS; k++)
				if (en[k])
					vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= NS; k++)
			if (en[k])
				pipe_s[k] <= nxt[k];
	end

	// Stage datapath
	always_comb begin
		logic signed [32:0] d33;
		logic        [32:0] mx;
		logic        [32:0] nm33;
		logic        [21:0] rem;
		logic        [23:0] sw;
		logic        [20:0] rt;
		logic        [21:0] dw;
		logic        [14:0] q;
		logic               dbit;
		logic signed [31:0] a32, b32;
		logic signed [47:0] a48, b48;
		logic signed [36:0] a37, b37;
		logic signed [38:0] rde;
		logic        [24:0] xw;
		logic        [31:0] tw;
		logic        [31:0] fw;
		logic        [20:0] nl21;
		logic        [35:0] t36;
		logic        [31:0] ev32;
		logic        [14:0] sh;
		logic        [31:0] t32;
		logic        [46:0] t47;
		logic        [34:0] acc;
		logic        [22:0] scaled;

		// light minus point, by magnitude and sign
		nxt[ST_DIFF] = '0;
		nxt[ST_DIFF].shadow = hit.in_shadow;
		nxt[ST_DIFF].colour = hit.surface_colour;
		nxt[ST_DIFF].nv = in_nv;
		nxt[ST_DIFF].ev = in_ev;
		for (int i = 0; i < 3; i++) begin
			d33 = 33'($signed(light_q[i])) - 33'($signed(pt[i]));
			nxt[ST_DIFF].neg[i] = d33[32];
			nxt[ST_DIFF].mag[i] = d33[32] ? 33'(-d33) : 33'(d33);
		end

		// largest magnitude and its top bit
		nxt[ST_MAX] = pipe_s[ST_MAX-1];
		mx = pipe_s[ST_MAX-1].mag[0];
		if (pipe_s[ST_MAX-1].mag[1] > mx) mx = pipe_s[ST_MAX-1].mag[1];
		if (pipe_s[ST_MAX-1].mag[2] > mx) mx = pipe_s[ST_MAX-1].mag[2];
		nxt[ST_MAX].pos = '0;
		for (int b = 0; b < 33; b++)
			if (mx[b]) nxt[ST_MAX].pos = 6'(b);
		nxt[ST_MAX].skip = (mx == '0) || pipe_s[ST_MAX-1].shadow;

		// scale so the largest lands in [2^19, 2^20)
		nxt[ST_NORM] = pipe_s[ST_NORM-1];
		for (int i = 0; i < 3; i++) begin
			if (pipe_s[ST_NORM-1].pos > 6'd19)
				nm33 = pipe_s[ST_NORM-1].mag[i] >> (pipe_s[ST_NORM-1].pos - 6'd19);
			else
				nm33 = pipe_s[ST_NORM-1].mag[i] << (6'd19 - pipe_s[ST_NORM-1].pos);
			nxt[ST_NORM].nmag[i] = nm33[19:0];
		end

		// squares
		nxt[ST_SQR] = pipe_s[ST_SQR-1];
		for (int i = 0; i < 3; i++)
			nxt[ST_SQR].sq[i] = 40'(pipe_s[ST_SQR-1].nmag[i]) * 40'(pipe_s[ST_SQR-1].nmag[i]);

		// sum of squares
		nxt[ST_SUM] = pipe_s[ST_SUM-1];
		nxt[ST_SUM].rad = 42'(pipe_s[ST_SUM-1].sq[0]) + 42'(pipe_s[ST_SUM-1].sq[1])
			+ 42'(pipe_s[ST_SUM-1].sq[2]);
		nxt[ST_SUM].srem = '0;
		nxt[ST_SUM].root = '0;

		// square root, three result bits per stage
		for (int s = 0; s < SQ_STAGES; s++) begin
			nxt[ST_SQ0+s] = pipe_s[ST_SQ0+s-1];
			rem = pipe_s[ST_SQ0+s-1].srem;
			rt = pipe_s[ST_SQ0+s-1].root;
			for (int t = 0; t < SQ_ITERS; t++) begin
				sw = {rem, pipe_s[ST_SQ0+s-1].rad[41-2*(SQ_ITERS*s+t) -: 2]};
				if (sw >= {1'b0, rt, 2'b01}) begin
					sw = sw - {1'b0, rt, 2'b01};
					rt = {rt[19:0], 1'b1};
				end else begin
					rt = {rt[19:0], 1'b0};
				end
				rem = sw[21:0];
			end
			nxt[ST_SQ0+s].srem = rem;
			nxt[ST_SQ0+s].root = rt;
		end

		// unit vector: (mag << 14) / len, three quotient bits per stage
		for (int s = 0; s < DV_STAGES; s++) begin
			nxt[ST_DV0+s] = pipe_s[ST_DV0+s-1];
			for (int i = 0; i < 3; i++) begin
				if (s == 0) begin
					rem = 22'(pipe_s[ST_DV0+s-1].nmag[i] >> 1);
					q = '0;
				end else begin
					rem = pipe_s[ST_DV0+s-1].drem[i];
					q = pipe_s[ST_DV0+s-1].quo[i];
				end
				for (int t = 0; t < DV_ITERS; t++) begin
					dbit = (DV_ITERS * s + t == 0) ? pipe_s[ST_DV0+s-1].nmag[i][0] : 1'b0;
					dw = {rem[20:0], dbit};
					if (dw >= 22'(pipe_s[ST_DV0+s-1].root)) begin
						dw = dw - 22'(pipe_s[ST_DV0+s-1].root);
						q = {q[13:0], 1'b1};
					end else begin
						q = {q[13:0], 1'b0};
					end
					rem = dw;
				end
				nxt[ST_DV0+s].drem[i] = rem;
				nxt[ST_DV0+s].quo[i] = q;
			end
		end

		// signed light vector and its products with the normal
		nxt[ST_LV] = pipe_s[ST_LV-1];
		for (int i = 0; i < 3; i++) begin
			nxt[ST_LV].lv[i] = pipe_s[ST_LV-1].neg[i] ? -16'(pipe_s[ST_LV-1].quo[i])
				: 16'(pipe_s[ST_LV-1].quo[i]);
			a32 = 32'($signed(nxt[ST_LV].lv[i]));
			b32 = 32'($signed(pipe_s[ST_LV-1].nv[i]));
			nxt[ST_LV].lnp[i] = a32 * b32;
		end

		// light dot normal
		nxt[ST_NDL] = pipe_s[ST_NDL-1];
		nxt[ST_NDL].ndl = 33'($signed(pipe_s[ST_NDL-1].lnp[0]))
			+ 33'($signed(pipe_s[ST_NDL-1].lnp[1]))
			+ 33'($signed(pipe_s[ST_NDL-1].lnp[2]));
		nxt[ST_NDL].lit = !pipe_s[ST_NDL-1].skip && !nxt[ST_NDL].ndl[32];

		// ndl times normal
		nxt[ST_RN] = pipe_s[ST_RN-1];
		for (int i = 0; i < 3; i++) begin
			a48 = 48'($signed(pipe_s[ST_RN-1].ndl));
			b48 = 48'($signed(pipe_s[ST_RN-1].nv[i]));
			nxt[ST_RN].rnp[i] = a48 * b48;
		end

		// reflected vector
		nxt[ST_RV] = pipe_s[ST_RV-1];
		for (int i = 0; i < 3; i++) begin
			a48 = $signed(pipe_s[ST_RV-1].rnp[i]) >>> 27;
			b48 = 48'($signed(pipe_s[ST_RV-1].lv[i]));
			a48 = a48 - b48;
			nxt[ST_RV].rv[i] = a48[20:0];
		end

		// reflect times eye
		nxt[ST_RE] = pipe_s[ST_RE-1];
		for (int i = 0; i < 3; i++) begin
			a37 = 37'($signed(pipe_s[ST_RE-1].rv[i]));
			b37 = 37'($signed(pipe_s[ST_RE-1].ev[i]));
			nxt[ST_RE].rep[i] = a37 * b37;
		end

		// reflect dot eye, clamped to one
		nxt[ST_RDE] = pipe_s[ST_RDE-1];
		rde = 39'($signed(pipe_s[ST_RDE-1].rep[0])) + 39'($signed(pipe_s[ST_RDE-1].rep[1]))
			+ 39'($signed(pipe_s[ST_RDE-1].rep[2]));
		nxt[ST_RDE].spec = pipe_s[ST_RDE-1].lit && !rde[38];
		xw = rde[38:14];
		nxt[ST_RDE].xq = (xw > 25'd16384) ? 15'd16384 : xw[14:0];

		// leading one and mantissa
		nxt[ST_LZ] = pipe_s[ST_LZ-1];
		nxt[ST_LZ].xzero = (pipe_s[ST_LZ-1].xq == '0);
		nxt[ST_LZ].lead = '0;
		for (int b = 0; b < 15; b++)
			if (pipe_s[ST_LZ-1].xq[b]) nxt[ST_LZ].lead = 4'(b);
		nxt[ST_LZ].mant = pipe_s[ST_LZ-1].xq << (4'd14 - nxt[ST_LZ].lead);

		// log table index
		nxt[ST_IDX] = pipe_s[ST_IDX-1];
		tw = ((32'(pipe_s[ST_IDX-1].mant) - 32'd16384) * 32'(POW_TABLE_DEPTH)) >> 14;
		nxt[ST_IDX].lidx = (tw > 32'(POW_TABLE_DEPTH - 1)) ? IDX_W'(POW_TABLE_DEPTH - 1)
			: tw[IDX_W-1:0];

		// negated log2, Q.16
		nxt[ST_LOG] = pipe_s[ST_LOG-1];
		nl21 = ((21'd14 - 21'(pipe_s[ST_LOG-1].lead)) << 16)
			- 21'(LOG_TAB[pipe_s[ST_LOG-1].lidx]);
		nxt[ST_LOG].nlog = nl21[19:0];

		// times shininess
		nxt[ST_POW] = pipe_s[ST_POW-1];
		t36 = 36'(pipe_s[ST_POW-1].nlog) * 36'(shin_q);
		nxt[ST_POW].pw = t36[35:6];

		// split into shift and exp table index
		nxt[ST_EIDX] = pipe_s[ST_EIDX-1];
		nxt[ST_EIDX].pint = pipe_s[ST_EIDX-1].pw[29:16];
		nxt[ST_EIDX].fzero = (pipe_s[ST_EIDX-1].pw[15:0] == '0);
		fw = 32'd65536 - 32'(pipe_s[ST_EIDX-1].pw[15:0]);
		tw = (fw * 32'(POW_TABLE_DEPTH)) >> 16;
		nxt[ST_EIDX].eidx = (tw > 32'(POW_TABLE_DEPTH - 1)) ? IDX_W'(POW_TABLE_DEPTH - 1)
			: tw[IDX_W-1:0];

		// specular factor, Q.14
		nxt[ST_EXP] = pipe_s[ST_EXP-1];
		ev32 = '0;
		sh = 15'(pipe_s[ST_EXP-1].pint) + 15'd1;
		if (pipe_s[ST_EXP-1].xzero) begin
			nxt[ST_EXP].factor = (shin_q == '0) ? 15'd16384 : 15'd0;
		end else if (pipe_s[ST_EXP-1].fzero) begin
			if (pipe_s[ST_EXP-1].pint < 14'd31)
				ev32 = 32'h4000_0000 >> pipe_s[ST_EXP-1].pint;
			nxt[ST_EXP].factor = ev32[30:16];
		end else begin
			if (sh < 15'd31)
				ev32 = 32'(EXP_TAB[pipe_s[ST_EXP-1].eidx]) >> sh;
			nxt[ST_EXP].factor = ev32[30:16];
		end

		// colour products
		nxt[ST_EFF] = pipe_s[ST_EFF-1];
		for (int c = 0; c < 3; c++) begin
			t32 = 32'(pipe_s[ST_EFF-1].colour[16*c +: 16]) * 32'(light_rgb_q[16*c +: 16]);
			nxt[ST_EFF].eff[c] = t32[31:14];
			nxt[ST_EFF].cke[c] = 28'(pipe_s[ST_EFF-1].colour[16*c +: 16]) * 28'(ke);
			nxt[ST_EFF].liks[c] = 28'(light_rgb_q[16*c +: 16]) * 28'(ks);
		end

		// coefficient products
		nxt[ST_MUL] = pipe_s[ST_MUL-1];
		for (int c = 0; c < 3; c++) begin
			nxt[ST_MUL].amb[c] = 30'(pipe_s[ST_MUL-1].eff[c]) * 30'(ka);
			nxt[ST_MUL].effkd[c] = 30'(pipe_s[ST_MUL-1].eff[c]) * 30'(kd);
			nxt[ST_MUL].specp[c] = 43'(pipe_s[ST_MUL-1].liks[c])
				* 43'(pipe_s[ST_MUL-1].factor);
		end

		// diffuse and specular terms
		nxt[ST_DIF] = pipe_s[ST_DIF-1];
		for (int c = 0; c < 3; c++) begin
			t47 = 47'(pipe_s[ST_DIF-1].effkd[c]) * 47'(pipe_s[ST_DIF-1].ndl[30:14]);
			nxt[ST_DIF].dif[c] = pipe_s[ST_DIF-1].lit ? t47[46:14] : '0;
			nxt[ST_DIF].spc[c] = pipe_s[ST_DIF-1].spec ? pipe_s[ST_DIF-1].specp[c][42:14]
				: '0;
		end

		// sum and saturate
		nxt[ST_OUT] = pipe_s[ST_OUT-1];
		nxt[ST_OUT].sat = 1'b0;
		for (int c = 0; c < 3; c++) begin
			acc = 35'(pipe_s[ST_OUT-1].amb[c]) + 35'(pipe_s[ST_OUT-1].cke[c])
				+ 35'(pipe_s[ST_OUT-1].dif[c]) + 35'(pipe_s[ST_OUT-1].spc[c]);
			scaled = acc[34:12];
			if (scaled > 23'h00FFFF) begin
				nxt[ST_OUT].chan[c] = 16'hFFFF;
				nxt[ST_OUT].sat = 1'b1;
			end else begin
				nxt[ST_OUT].chan[c] = scaled[15:0];
			end
		end
	end

	assign pixel.valid     = vld_s[NS];
	assign pixel.out_red   = pipe_s[NS].chan[0];
	assign pixel.out_green = pipe_s[NS].chan[1];
	assign pixel.out_blue  = pipe_s[NS].chan[2];
	assign pixel.saturated = pipe_s[NS].sat;

	// An empty output stage frees the whole enable chain
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[NS] |-> hit.ready)
		else $error("input stalled with an empty output stage");

	// Shadowed or degenerate points never get lit
	a_skip_not_lit: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_NDL] && pipe_s[ST_NDL].skip |-> !pipe_s[ST_NDL].lit)
		else $error("lit flag set on a skipped point");

	// Specular only where diffuse is on
	a_spec_needs_lit: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_RDE] && pipe_s[ST_RDE].spec |-> pipe_s[ST_RDE].lit)
		else $error("specular enabled on an unlit point");

	// Power factor never exceeds one
	a_factor_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_EXP] |-> pipe_s[ST_EXP].factor <= 15'd16384)
		else $error("specular factor above one");

endmodule
